// ===== hdl/weighted_mean_variance_top_macros.svh =====
// assertion macros shared by the checker
`ifndef WEIGHTED_MEAN_VARIANCE_TOP_MACROS_SVH
`define WEIGHTED_MEAN_VARIANCE_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define WMV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, held off during reset
`define WMV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/wmv_pkg.sv =====
// package with types and constants of the weighted mean and variance block
`timescale 1ns / 1ps
package wmv_pkg;

  localparam int unsigned MAX_ITEMS = 1024;
  localparam int unsigned CNT_W     = 11;
  localparam logic [27:0] WSUM_MAX  = 28'hFFFFFFF;
  localparam logic [16:0] WEIGHT_ONE = 17'd65536;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAG,
    ST_PROD,
    ST_DIV,
    ST_MEAN,
    ST_MOM,
    ST_ACC,
    ST_CHK,
    ST_FDIV1,
    ST_FDIV2,
    ST_SQRT,
    ST_OUT
  } wmv_state_e;

endpackage

// ===== hdl/weighted_mean_variance_top.sv =====
// weighted running mean and sigma of a rated item stream, west's method
// an item is taken in ST_IDLE; a scored one then runs ST_MAG, a multiply, one 64-step divide
// on the shared restoring divider, two multiplies and ST_ACC; s_axis_tready is low meanwhile
// a last item of at least two samples adds two more 64-step divides and a 32-step square root
// the result sits in an output register, so the next item may enter while it waits
// rst_ni is asynchronous and active low and clears all running sums and the control state
`timescale 1ns / 1ps
module weighted_mean_variance_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // day_score, night_score, weight, zero fill
  input  logic        s_axis_tlast,  // last_item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // mean_score, spread, sample_count, zero fill
  output logic        m_axis_tuser   // status
);
  import wmv_pkg::*;

  wmv_state_e state_q, state_d;

  logic [31:0] x_q, x_d;
  logic [16:0] w_q, w_d;
  logic        last_q, last_d;
  logic        scored_q, scored_d;
  logic        up_q, up_d;
  logic [31:0] mag_q, mag_d;
  logic [63:0] prod_q, prod_d;
  logic [31:0] mean_q, mean_d;
  logic [63:0] m2_q, m2_d;
  logic [27:0] wsum_q, wsum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [63:0] dq_q, dq_d;
  logic [34:0] rem_q, rem_d;
  logic [28:0] divisor_q, divisor_d;
  logic [31:0] root_q, root_d;
  logic [5:0]  it_q, it_d;
  logic [63:0] v1_q, v1_d;
  logic [15:0] sigma_q, sigma_d;
  logic        stat_q, stat_d;
  logic        ovalid_q, ovalid_d;
  logic [47:0] odata_q, odata_d;
  logic        ouser_q, ouser_d;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // shared divider step
  logic [29:0] div_sh;
  logic        div_ge;
  logic [29:0] div_rem;
  logic [63:0] div_quot;
  assign div_sh   = {rem_q[28:0], dq_q[63]};
  assign div_ge   = div_sh >= {1'b0, divisor_q};
  assign div_rem  = div_ge ? (div_sh - {1'b0, divisor_q}) : div_sh;
  assign div_quot = {dq_q[62:0], div_ge};

  // square root step
  logic [34:0] sq_sh, sq_trial, sq_rem;
  logic        sq_ge;
  assign sq_sh    = {rem_q[32:0], dq_q[63:62]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;
  assign sq_rem   = sq_ge ? (sq_sh - sq_trial) : sq_sh;

  logic [15:0] in_day, in_night;
  logic [16:0] in_w;
  assign in_day   = s_axis_tdata[15:0];
  assign in_night = s_axis_tdata[31:16];
  assign in_w     = s_axis_tdata[48:32];

  logic [28:0] t_sum;
  assign t_sum = {1'b0, wsum_q} + 29'(w_q);

  logic [64:0] m2_sum, v_sum;
  logic [32:0] mean_rnd;
  assign m2_sum   = {1'b0, m2_q} + {1'b0, prod_q};
  assign v_sum    = {1'b0, v1_q} + {1'b0, div_quot};
  assign mean_rnd = {1'b0, mean_q} + 33'd32768;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

  always_comb begin
    state_d   = state_q;
    x_d       = x_q;
    w_d       = w_q;
    last_d    = last_q;
    scored_d  = scored_q;
    up_d      = up_q;
    mag_d     = mag_q;
    prod_d    = prod_q;
    mean_d    = mean_q;
    m2_d      = m2_q;
    wsum_d    = wsum_q;
    cnt_d     = cnt_q;
    dq_d      = dq_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    root_d    = root_q;
    it_d      = it_q;
    v1_d      = v1_q;
    sigma_d   = sigma_q;
    stat_d    = stat_q;
    ovalid_d  = ovalid_q & ~m_axis_tready;
    odata_d   = odata_q;
    ouser_d   = ouser_q;
    mul_a     = mag_q;
    mul_b     = 32'(w_q);

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          scored_d = 1'b1;
          if (in_day != 16'd0) begin
            x_d = (in_night != 16'd0) ? ({15'd0, 17'(in_day) + 17'(in_night)} << 15)
                                      : {in_day, 16'd0};
          end else if (in_night != 16'd0) begin
            x_d = {in_night, 16'd0};
          end else begin
            x_d      = 32'd0;
            scored_d = 1'b0;
          end
          if (in_w == 17'd0) w_d = 17'd1;
          else if (in_w > WEIGHT_ONE) w_d = WEIGHT_ONE;
          else w_d = in_w;
          last_d  = s_axis_tlast;
          state_d = ST_MAG;
        end
      end
      ST_MAG: begin
        up_d  = x_q >= mean_q;
        mag_d = (x_q >= mean_q) ? (x_q - mean_q) : (mean_q - x_q);
        if (scored_q && (32'(cnt_q) < MAX_ITEMS)) state_d = ST_PROD;
        else state_d = ST_CHK;
      end
      ST_PROD: begin
        dq_d      = mul_p;
        divisor_d = t_sum;
        rem_d     = 35'd0;
        it_d      = 6'd0;
        state_d   = ST_DIV;
      end
      ST_DIV, ST_FDIV1, ST_FDIV2: begin
        dq_d  = div_quot;
        rem_d = {5'd0, div_rem};
        it_d  = it_q + 6'd1;
        if (it_q == 6'd63) begin
          it_d  = 6'd0;
          rem_d = 35'd0;
          if (state_q == ST_DIV) begin
            state_d = ST_MEAN;
          end else if (state_q == ST_FDIV1) begin
            v1_d      = div_quot;
            divisor_d = 29'(cnt_q - CNT_W'(1));
            state_d   = ST_FDIV2;
          end else begin
            dq_d    = v_sum[64] ? {64{1'b1}} : v_sum[63:0];
            root_d  = 32'd0;
            state_d = ST_SQRT;
          end
        end
      end
      ST_MEAN: begin
        mean_d  = up_q ? (mean_q + dq_q[31:0]) : (mean_q - dq_q[31:0]);
        mul_a   = {8'd0, mag_q[31:8]};
        mul_b   = {8'd0, dq_q[31:8]};
        prod_d  = mul_p;
        state_d = ST_MOM;
      end
      ST_MOM: begin
        mul_a   = {4'd0, wsum_q};
        mul_b   = prod_q[47:16];
        prod_d  = mul_p;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        m2_d    = m2_sum[64] ? {64{1'b1}} : m2_sum[63:0];
        wsum_d  = (t_sum > {1'b0, WSUM_MAX}) ? WSUM_MAX : t_sum[27:0];
        cnt_d   = cnt_q + CNT_W'(1);
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (cnt_q < CNT_W'(2)) begin
          sigma_d = 16'd0;
          stat_d  = 1'b1;
          state_d = ST_OUT;
        end else begin
          dq_d      = m2_q;
          divisor_d = {1'b0, wsum_q};
          rem_d     = 35'd0;
          it_d      = 6'd0;
          state_d   = ST_FDIV1;
        end
      end
      ST_SQRT: begin
        rem_d  = sq_rem;
        root_d = {root_q[30:0], sq_ge};
        dq_d   = {dq_q[61:0], 2'b00};
        it_d   = it_q + 6'd1;
        if (it_q == 6'd31) begin
          sigma_d = (root_q[30:15] != 16'd0) ? 16'hFFFF : {root_q[14:0], sq_ge};
          stat_d  = 1'b0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d  = {5'd0, cnt_q, sigma_q,
                      mean_rnd[32] ? 16'hFFFF : mean_rnd[31:16]};
          ouser_d  = stat_q;
          mean_d   = 32'd0;
          m2_d     = 64'd0;
          wsum_d   = 28'd0;
          cnt_d    = '0;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      mean_q   <= 32'd0;
      m2_q     <= 64'd0;
      wsum_q   <= 28'd0;
      cnt_q    <= '0;
      it_q     <= 6'd0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      mean_q   <= mean_d;
      m2_q     <= m2_d;
      wsum_q   <= wsum_d;
      cnt_q    <= cnt_d;
      it_q     <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    w_q       <= w_d;
    last_q    <= last_d;
    scored_q  <= scored_d;
    up_q      <= up_d;
    mag_q     <= mag_d;
    prod_q    <= prod_d;
    dq_q      <= dq_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
    root_q    <= root_d;
    v1_q      <= v1_d;
    sigma_q   <= sigma_d;
    stat_q    <= stat_d;
    odata_q   <= odata_d;
    ouser_q   <= ouser_d;
  end

endmodule

// ===== hdl/wmv_checker.sv =====
// port-level checker for the weighted mean and variance block, with its bind
`timescale 1ns / 1ps
`include "weighted_mean_variance_top_macros.svh"
module wmv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [55:0] s_axis_tdata,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  // a pending result stays until taken
  `WMV_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  // one item at a time: busy right after a transaction
  `WMV_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // short group gives zero spread
  `WMV_ASSERT_NOW(a_short_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata[31:16] == 16'd0)
  // ok status needs at least two samples
  `WMV_ASSERT_NOW(a_ok_count, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[42:33] != 10'd0)
endmodule

bind weighted_mean_variance_top wmv_checker u_wmv_checker (.*);

// ===== dv/tb_weighted_mean_variance_top.sv =====
// testbench for the weighted mean and variance block: random and directed streams, scored
`timescale 1ns / 1ps
module tb_weighted_mean_variance_top;
  import wmv_pkg::*;

  typedef struct packed {
    logic [10:0] count;
    logic [15:0] sigma;
    logic [15:0] mean;
    logic        flag;
  } group_result_t;

  class group_scoreboard;
    logic [63:0] mean_acc, m2_acc, wsum_acc, n_acc;
    group_result_t pending[$];
    int errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      mean_acc = 0; m2_acc = 0; wsum_acc = 0; n_acc = 0;
    endfunction

    function logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      return (s < a) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note_item(logic [15:0] day, logic [15:0] night, logic [16:0] wt, logic lst);
      logic [63:0] x, w, t, mag, r, p, v, mq, sg;
      logic up;
      group_result_t res;
      x = 0;
      if (day != 0) x = (night != 0) ? ((64'(day) + night) << 15) : (64'(day) << 16);
      else if (night != 0) x = 64'(night) << 16;
      if (x != 0 && n_acc < MAX_ITEMS) begin
        w = wt;
        if (w == 0) w = 1;
        if (w > 65536) w = 65536;
        t = wsum_acc + w;
        up = x >= mean_acc;
        mag = up ? x - mean_acc : mean_acc - x;
        r = (mag * w) / t;
        mean_acc = (up ? mean_acc + r : mean_acc - r) & 64'hFFFF_FFFF;
        p = ((mag >> 8) * (r >> 8)) >> 16;
        m2_acc = sadd(m2_acc, wsum_acc * p);
        wsum_acc = (t > 64'h0FFF_FFFF) ? 64'h0FFF_FFFF : t;
        n_acc++;
      end
      if (!lst) return;
      mq = (mean_acc + 32768) >> 16;
      if (mq > 16'hFFFF) mq = 16'hFFFF;
      sg = 0;
      res.flag = 1;
      if (n_acc >= 2 && wsum_acc != 0) begin
        v = m2_acc / wsum_acc;
        v = sadd(v, v / (n_acc - 1));
        sg = int_sqrt(v);
        if (sg > 16'hFFFF) sg = 16'hFFFF;
        res.flag = 0;
      end
      res.mean = mq[15:0];
      res.sigma = sg[15:0];
      res.count = (n_acc > 11'h7FF) ? 11'h7FF : n_acc[10:0];
      pending = {pending, res};
      clear();
    endfunction

    task report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(logic [47:0] data, logic st);
      group_result_t e;
      if (pending.size() == 0) begin
        report("unexpected result", data[15:0], 0);
        return;
      end
      e = pending.pop_front();
      if (data[15:0] !== e.mean) report("mean_score", data[15:0], e.mean);
      if (data[31:16] !== e.sigma) report("spread", data[31:16], e.sigma);
      if (data[42:32] !== e.count) report("sample_count", data[42:32], e.count);
      if (st !== e.flag) report("status", st, e.flag);
    endtask
  endclass

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [55:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [47:0] m_axis_tdata;
  group_scoreboard sb;
  bit hold_sink, src_done;

  weighted_mean_variance_top dut (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
  endfunction

  task send_item(logic [15:0] day, logic [15:0] night, logic [16:0] wt, logic lst);
    int gap;
    s_axis_tvalid <= 1;
    s_axis_tdata <= {7'd0, wt, night, day};
    s_axis_tlast <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(day, night, wt, lst);
    gap = gap_len();
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function logic [15:0] rnd_score();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  function logic [16:0] rnd_weight();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom_range(65537, 131071));
      3: return 17'd1;
      default: return 17'($urandom_range(1, 65536));
    endcase
  endfunction

  // sink side: random stalls, honors the long hold-off flag
  initial begin
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if (hold_sink) m_axis_tready <= 0;
      else m_axis_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 9) == 0);
    end
  end

  initial begin
    int sent, len;
    sb = new();
    rst_ni = 0;
    s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tlast = 0;
    hold_sink = 0; src_done = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: empty, single, pairs, extremes, no score, weight clamping
    send_item(0, 0, 5, 1);
    send_item(16'h0100, 0, 65536, 1);
    send_item(0, 16'h0200, 1, 1);
    send_item(16'hFFFF, 16'hFFFF, 65536, 0);
    send_item(16'h0001, 16'h0001, 0, 1);
    send_item(16'hFFFF, 0, 131071, 0);
    send_item(0, 0, 100, 0);
    send_item(0, 16'h0001, 65536, 1);
    send_item(16'h1234, 16'h5678, 30000, 0);
    send_item(16'h8000, 16'h0100, 1, 0);
    send_item(16'h0001, 16'hFFFF, 65535, 0);
    send_item(0, 0, 0, 1);
    send_item(16'hAAAA, 16'h5555, 17'h1FFFF, 0);
    send_item(16'h5555, 16'hAAAA, 17'h15555, 0);
    send_item(16'hFFFF, 16'hFFFF, 17'h0AAAA, 1);
    // wait until drained
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    // long sink hold while source keeps offering
    fork
      begin
        hold_sink = 1;
        repeat (3000) @(posedge clk_i);
        hold_sink = 0;
      end
    join_none
    sent = 15;
    while (sent < 565) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 15) == 0) send_item(0, 0, rnd_weight(), i == len - 1);
        else send_item(rnd_score(), rnd_score(), rnd_weight(), i == len - 1);
        sent++;
      end
    end
    s_axis_tvalid <= 0;
    src_done = 1;
  end

  initial begin
    wait (src_done);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (sb.errors == 0) $display("tb_weighted_mean_variance_top: PASS");
    else $display("tb_weighted_mean_variance_top: FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_weighted_mean_variance_top: FAIL");
    $finish;
  end
endmodule
